### src/pckrb_pkg.sv
// package for the particle coriolis kick and radial binning block
// holds histogram sizing, operation and register codes, and the sequencer states
// no dependencies
package pckrb_pkg;

    localparam int NUM_BINS = 1024;
    localparam int BIN_AW   = $clog2(NUM_BINS);

    localparam logic [1:0] FUNC_KICK     = 2'd0;
    localparam logic [1:0] FUNC_KICK_BIN = 2'd1;
    localparam logic [1:0] FUNC_READ     = 2'd2;
    localparam logic [1:0] FUNC_READ_CLR = 2'd3;

    localparam logic [2:0] REG_POS_OFF_X     = 3'd0;
    localparam logic [2:0] REG_POS_OFF_Y     = 3'd1;
    localparam logic [2:0] REG_POS_OFF_Z     = 3'd2;
    localparam logic [2:0] REG_VEL_OFF_XY    = 3'd3;
    localparam logic [2:0] REG_CORIOLIS_GAIN = 3'd4;
    localparam logic [2:0] REG_ROT_RADIUS    = 3'd5;
    localparam logic [2:0] REG_BIN_ORIGIN    = 3'd6;
    localparam logic [2:0] REG_BIN_SCALE     = 3'd7;

    localparam logic [31:0] BIN_SCALE_RESET = 32'd65536;
    localparam logic [47:0] MASS_MAX        = {48{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_SCALE,
        ST_RD,
        ST_UPD,
        ST_DONE
    } state_t;

endpackage

### src/particle_coriolis_kick_radial_binning.sv
// top level of the particle coriolis kick and radial binning block
// depends on pckrb_pkg for sizing, codes and states
// Usage: one transaction in, one result out. After reset the histogram memory is
// swept to zero, one bin per cycle, over all NUM_BINS (1024) bins, during which
// in_stall stays high; configuration writes are taken at any time. A particle
// transaction goes through five passes through one shared 33x33 multiplier (three
// squares, two kick products), the bit-pair square root, one scale multiply, a
// read-modify-write on the histogram memory when binning, the hand-over of the
// result and a return to idle to take the next transaction. A bin read or
// read-clear goes through the read, update and hand-over states. out_stall on a
// waiting result holds the hand-over. A new transaction is taken while a finished
// result still waits.
module particle_coriolis_kick_radial_binning
    import pckrb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic [31:0]         mass,
    input  logic [9:0]          bin_addr,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  dvel_x,
    output logic signed [31:0]  dvel_y,
    output logic                kick_applied,
    output logic                binned,
    output logic [47:0]         bin_mass
);

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            r = v[31:0];
        return r;
    endfunction

    // floor of product over 2^16, saturated
    function automatic logic signed [31:0] kick_sat(input logic signed [65:0] p);
        logic signed [65:0] q;
        logic signed [31:0] r;
        q = p >>> 16;
        if (q > 66'sh0_7fff_ffff)
            r = 32'sh7fff_ffff;
        else if (q < -66'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = q[31:0];
        return r;
    endfunction

    // configuration registers
    logic signed [31:0] pos_off_x_reg, pos_off_y_reg, pos_off_z_reg;
    logic signed [31:0] vel_off_x_reg, vel_off_y_reg, gain_reg;
    logic [30:0]        rot_radius_reg, bin_origin_reg;
    logic [31:0]        bin_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_off_x_reg  <= '0;
            pos_off_y_reg  <= '0;
            pos_off_z_reg  <= '0;
            vel_off_x_reg  <= '0;
            vel_off_y_reg  <= '0;
            gain_reg       <= '0;
            rot_radius_reg <= '0;
            bin_origin_reg <= '0;
            bin_scale_reg  <= BIN_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POS_OFF_X:     pos_off_x_reg  <= cfg_data[31:0];
                REG_POS_OFF_Y:     pos_off_y_reg  <= cfg_data[31:0];
                REG_POS_OFF_Z:     pos_off_z_reg  <= cfg_data[31:0];
                REG_VEL_OFF_XY:
                begin
                    vel_off_x_reg <= cfg_data[31:0];
                    vel_off_y_reg <= cfg_data[63:32];
                end
                REG_CORIOLIS_GAIN: gain_reg       <= cfg_data[31:0];
                REG_ROT_RADIUS:    rot_radius_reg <= cfg_data[30:0];
                REG_BIN_ORIGIN:    bin_origin_reg <= cfg_data[30:0];
                REG_BIN_SCALE:     bin_scale_reg  <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    // sequencer and datapath registers
    state_t state_reg, state_next;
    logic [BIN_AW:0]    clr_cnt_reg, clr_cnt_next;
    logic [2:0]         mul_cnt_reg, mul_cnt_next;
    logic [4:0]         sq_cnt_reg, sq_cnt_next;
    logic               out_valid_reg, out_valid_next;

    logic [1:0]         func_reg;
    logic [31:0]        mass_reg;
    logic [9:0]         addr_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg, vx_reg, vy_reg;
    logic [63:0]        r2_reg;
    logic [63:0]        op_reg, res_reg, one_reg;
    logic signed [31:0] kx_reg, ky_reg;
    logic               kick_reg;
    logic [63:0]        scaled_reg;

    logic signed [31:0] dvx_reg, dvy_reg;
    logic               kick_out_reg, binned_reg;
    logic [47:0]        bmass_reg;

    // histogram memory
    logic [47:0]        mem [NUM_BINS];
    logic               mem_we;
    logic [BIN_AW-1:0]  mem_waddr, mem_raddr;
    logic [47:0]        mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    always_comb
    begin
        case (mul_cnt_reg)
            3'd0:    begin mul_a = 33'(px_reg);   mul_b = 33'(px_reg);  end
            3'd1:    begin mul_a = 33'(py_reg);   mul_b = 33'(py_reg);  end
            3'd2:    begin mul_a = 33'(pz_reg);   mul_b = 33'(pz_reg);  end
            3'd3:    begin mul_a = 33'(gain_reg); mul_b = 33'(vy_reg);  end
            default: begin mul_a = 33'(gain_reg); mul_b = -33'(vx_reg); end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // square root step
    logic [63:0] sq_trial;
    logic        sq_take;
    assign sq_trial = res_reg + one_reg;
    assign sq_take  = op_reg >= sq_trial;

    // radius, bin index and range checks
    logic [31:0] radius;
    logic [31:0] rdiff;
    logic [31:0] bin_idx;
    logic        idx_ok, addr_ok;
    logic [48:0] mass_sum;
    assign radius   = res_reg[31:0];
    assign rdiff    = (radius > {1'b0, bin_origin_reg}) ? radius - {1'b0, bin_origin_reg}
                                                        : 32'd0;
    assign bin_idx  = scaled_reg[63:32];
    assign idx_ok   = bin_idx < 32'(NUM_BINS);
    assign addr_ok  = 32'(addr_reg) < 32'(NUM_BINS);
    assign mass_sum = {1'b0, mem_rdata} + 49'(mass_reg);

    logic accept;
    assign accept = in_valid && !in_stall;

    // next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        mul_cnt_next   = mul_cnt_reg;
        sq_cnt_next    = sq_cnt_reg;
        out_valid_next = out_valid_reg;
        in_stall       = 1'b1;
        mem_we         = 1'b0;
        mem_waddr      = clr_cnt_reg[BIN_AW-1:0];
        mem_wdata      = '0;
        mem_raddr      = addr_reg[BIN_AW-1:0];

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (BIN_AW+1)'(NUM_BINS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                mul_cnt_next = '0;
                sq_cnt_next  = '0;
                if (accept)
                    state_next = (func == FUNC_READ || func == FUNC_READ_CLR) ? ST_RD
                                                                              : ST_MUL;
            end
            ST_MUL:
            begin
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == 3'd4)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 5'd31)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = (func_reg == FUNC_KICK_BIN) ? ST_RD : ST_DONE;
            end
            ST_RD:
            begin
                if (func_reg == FUNC_KICK_BIN)
                    mem_raddr = bin_idx[BIN_AW-1:0];
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (func_reg == FUNC_KICK_BIN)
                begin
                    mem_waddr = bin_idx[BIN_AW-1:0];
                    mem_we    = idx_ok;
                    mem_wdata = mass_sum[48] ? MASS_MAX : mass_sum[47:0];
                end
                else
                begin
                    mem_waddr = addr_reg[BIN_AW-1:0];
                    mem_we    = addr_ok && (func_reg == FUNC_READ_CLR);
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            mul_cnt_reg   <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            mul_cnt_reg   <= mul_cnt_next;
            sq_cnt_reg    <= sq_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                func_reg <= func;
                mass_reg <= mass;
                addr_reg <= bin_addr;
                px_reg   <= sat33(33'(pos_x) - 33'(pos_off_x_reg));
                py_reg   <= sat33(33'(pos_y) - 33'(pos_off_y_reg));
                pz_reg   <= sat33(33'(pos_z) - 33'(pos_off_z_reg));
                vx_reg   <= sat33(33'(vel_x) - 33'(vel_off_x_reg));
                vy_reg   <= sat33(33'(vel_y) - 33'(vel_off_y_reg));
                r2_reg   <= '0;
                res_reg  <= '0;
                one_reg  <= 64'h4000_0000_0000_0000;
            end
            ST_MUL:
            begin
                case (mul_cnt_reg)
                    3'd0, 3'd1, 3'd2: r2_reg <= r2_reg + mul_p[63:0];
                    3'd3:             kx_reg <= kick_sat(mul_p);
                    default:
                    begin
                        ky_reg <= kick_sat(mul_p);
                        op_reg <= r2_reg;
                    end
                endcase
            end
            ST_SQRT:
            begin
                if (sq_take)
                begin
                    op_reg  <= op_reg - sq_trial;
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                one_reg <= one_reg >> 2;
            end
            ST_SCALE:
            begin
                scaled_reg <= 64'(rdiff) * 64'(bin_scale_reg);
                kick_reg   <= (rot_radius_reg == '0) || (radius < {1'b0, rot_radius_reg});
            end
            default: ;
        endcase

        // result register
        if (state_reg == ST_SCALE || state_reg == ST_UPD)
        begin
            if (func_reg == FUNC_KICK || func_reg == FUNC_KICK_BIN)
            begin
                if (state_reg == ST_SCALE)
                begin
                    kick_out_reg <= (rot_radius_reg == '0)
                                    || (radius < {1'b0, rot_radius_reg});
                    if ((rot_radius_reg == '0) || (radius < {1'b0, rot_radius_reg}))
                    begin
                        dvx_reg <= kx_reg;
                        dvy_reg <= ky_reg;
                    end
                    else
                    begin
                        dvx_reg <= '0;
                        dvy_reg <= '0;
                    end
                    binned_reg <= 1'b0;
                    bmass_reg  <= '0;
                end
                else
                    binned_reg <= idx_ok;
            end
            else
            begin
                dvx_reg      <= '0;
                dvy_reg      <= '0;
                kick_out_reg <= 1'b0;
                binned_reg   <= 1'b0;
                bmass_reg    <= addr_ok ? mem_rdata : '0;
            end
        end
    end

    // output register, loaded when the result is handed over
    logic signed [31:0] dvel_x_reg, dvel_y_reg;
    logic               kick_applied_reg, binned_o_reg;
    logic [47:0]        bin_mass_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
        begin
            dvel_x_reg       <= dvx_reg;
            dvel_y_reg       <= dvy_reg;
            kick_applied_reg <= kick_out_reg && kick_reg;
            binned_o_reg     <= binned_reg;
            bin_mass_reg     <= bmass_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dvel_x       = dvel_x_reg;
    assign dvel_y       = dvel_y_reg;
    assign kick_applied = kick_applied_reg;
    assign binned       = binned_o_reg;
    assign bin_mass     = bin_mass_reg;

endmodule

### dv/tb_particle_coriolis_kick_radial_binning.sv
// testbench for particle_coriolis_kick_radial_binning: directed and random particles and bin reads
// scored against an in-bench predictor of the kick, the radius and the histogram
// depends on pckrb_pkg and the block's rtl
module tb_particle_coriolis_kick_radial_binning;
    import pckrb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y;
        logic [31:0]        mass;
        logic [9:0]         bin_addr;
    } particle_t;

    typedef struct {
        logic signed [31:0] dvel_x, dvel_y;
        logic               kick_applied, binned;
        logic [47:0]        bin_mass;
    } kick_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = REG_POS_OFF_X;
    logic [63:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = FUNC_KICK;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, vel_x = '0, vel_y = '0;
    logic [31:0] mass = '0;
    logic [9:0] bin_addr = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] dvel_x, dvel_y;
    logic kick_applied, binned;
    logic [47:0] bin_mass;

    particle_t    pending_particles[$];
    kick_result_t expected_kicks[$];
    particle_t    cur_particle;
    logic         had_error = 1'b0;
    logic         no_idle = 1'b0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           quiet_cycles = 0;

    // predictor copy of registers and histogram
    longint      off_x, off_y, off_z, voff_x, voff_y, gain;
    logic [63:0] rot_lim, origin, scale;
    logic [47:0] hist_mass [NUM_BINS];

    particle_coriolis_kick_radial_binning dut (.*);

    always #10 clk = ~clk;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] op, res, one;
        op = v;
        res = '0;
        one = 64'd1 << 62;
        while (one > op)
            one = one >> 2;
        while (one != 0)
        begin
            if (op >= res + one)
            begin
                op = op - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    // q32.32 product floored to q16.16, saturated
    function automatic logic [31:0] coriolis_product(longint a, longint b);
        longint p;
        p = a * b;
        return 32'(clip32(p >>> 16));
    endfunction

    function automatic kick_result_t predict_kick_bin(particle_t it);
        kick_result_t res;
        longint px, py, pz, vx, vy;
        logic [63:0] r2, r, idx, s;
        res = '{default: '0};
        if (it.func == FUNC_READ || it.func == FUNC_READ_CLR)
        begin
            res.bin_mass = hist_mass[it.bin_addr];
            if (it.func == FUNC_READ_CLR)
                hist_mass[it.bin_addr] = '0;
        end
        else
        begin
            px = clip32(longint'(it.pos_x) - off_x);
            py = clip32(longint'(it.pos_y) - off_y);
            pz = clip32(longint'(it.pos_z) - off_z);
            vx = clip32(longint'(it.vel_x) - voff_x);
            vy = clip32(longint'(it.vel_y) - voff_y);
            r2 = 64'(px * px) + 64'(py * py) + 64'(pz * pz);
            r = root64(r2);
            if (it.func == FUNC_KICK_BIN)
            begin
                idx = '0;
                if (r > origin)
                    idx = ((r - origin) * scale) >> 32;
                if (idx < NUM_BINS)
                begin
                    s = 64'(hist_mass[idx]) + 64'(it.mass);
                    if (s > 64'(MASS_MAX))
                        s = 64'(MASS_MAX);
                    hist_mass[idx] = s[47:0];
                    res.binned = 1'b1;
                end
            end
            if (rot_lim == 0 || r < rot_lim)
            begin
                res.kick_applied = 1'b1;
                res.dvel_x = coriolis_product(gain, vy);
                res.dvel_y = coriolis_product(gain, -vx);
            end
        end
        return res;
    endfunction

    // driver: one transaction at a time from the pending queue
    always @(posedge clk)
    begin
        logic next_valid;
        next_valid = in_valid;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_kicks.push_back(predict_kick_bin(cur_particle));
            send_gap = no_idle ? 0 : $urandom_range(0, 9);
            next_valid = 1'b0;
        end
        if (!rst_n)
            next_valid = 1'b0;
        else if (!next_valid)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_particles.size() > 0)
            begin
                cur_particle = pending_particles.pop_front();
                func <= cur_particle.func;
                pos_x <= cur_particle.pos_x;
                pos_y <= cur_particle.pos_y;
                pos_z <= cur_particle.pos_z;
                vel_x <= cur_particle.vel_x;
                vel_y <= cur_particle.vel_y;
                mass <= cur_particle.mass;
                bin_addr <= cur_particle.bin_addr;
                next_valid = 1'b1;
            end
        end
        in_valid <= next_valid;
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        kick_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_kicks.size() == 0)
            begin
                $error("result with no expectation waiting");
                had_error = 1'b1;
            end
            else
            begin
                exp_r = expected_kicks.pop_front();
                if (dvel_x !== exp_r.dvel_x)
                begin
                    $error("dvel_x expected %0d actual %0d", exp_r.dvel_x, dvel_x);
                    had_error = 1'b1;
                end
                if (dvel_y !== exp_r.dvel_y)
                begin
                    $error("dvel_y expected %0d actual %0d", exp_r.dvel_y, dvel_y);
                    had_error = 1'b1;
                end
                if (kick_applied !== exp_r.kick_applied)
                begin
                    $error("kick_applied expected %0b actual %0b",
                           exp_r.kick_applied, kick_applied);
                    had_error = 1'b1;
                end
                if (binned !== exp_r.binned)
                begin
                    $error("binned expected %0b actual %0b", exp_r.binned, binned);
                    had_error = 1'b1;
                end
                if (bin_mass !== exp_r.bin_mass)
                begin
                    $error("bin_mass expected %0d actual %0d", exp_r.bin_mass, bin_mass);
                    had_error = 1'b1;
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 9);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog on cycles with no accepted transaction and no taken result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        case (idx)
            REG_POS_OFF_X:     off_x = longint'($signed(d[31:0]));
            REG_POS_OFF_Y:     off_y = longint'($signed(d[31:0]));
            REG_POS_OFF_Z:     off_z = longint'($signed(d[31:0]));
            REG_VEL_OFF_XY:
            begin
                voff_x = longint'($signed(d[31:0]));
                voff_y = longint'($signed(d[63:32]));
            end
            REG_CORIOLIS_GAIN: gain = longint'($signed(d[31:0]));
            REG_ROT_RADIUS:    rot_lim = {33'd0, d[30:0]};
            REG_BIN_ORIGIN:    origin = {33'd0, d[30:0]};
            REG_BIN_SCALE:     scale = {32'd0, d[31:0]};
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [63:0] v[8]);
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), v[i]);
    endtask

    // sampled away from the rising edge so the driver's updates have settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_particles.size() > 0 || in_valid || expected_kicks.size() > 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic particle_t mk(logic [1:0] f, logic [31:0] px, logic [31:0] py,
                                     logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                                     logic [31:0] m, logic [9:0] a);
        particle_t p;
        p.func = f;
        p.pos_x = px;
        p.pos_y = py;
        p.pos_z = pz;
        p.vel_x = vx;
        p.vel_y = vy;
        p.mass = m;
        p.bin_addr = a;
        return p;
    endfunction

    // mostly small coordinates so that particles land in the histogram
    function automatic logic [31:0] coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        int sel;
        sel = $urandom_range(0, 99);
        p.func = sel < 40 ? FUNC_KICK_BIN : sel < 70 ? FUNC_KICK :
                 sel < 85 ? FUNC_READ : FUNC_READ_CLR;
        p.pos_x = coord();
        p.pos_y = coord();
        p.pos_z = coord();
        p.vel_x = coord();
        p.vel_y = coord();
        p.mass = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20);
        p.bin_addr = $urandom_range(0, 4) == 0 ? 10'($urandom) : 10'($urandom_range(0, 63));
        return p;
    endfunction

    initial
    begin
        logic [63:0] regs[8];
        off_x = 0; off_y = 0; off_z = 0; voff_x = 0; voff_y = 0; gain = 0;
        rot_lim = 0; origin = 0; scale = 64'(BIN_SCALE_RESET);
        for (int i = 0; i < NUM_BINS; i++)
            hist_mass[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // phase 0: unit gain, radius 100.0, unit bin width
        regs = '{0, 0, 0, 0, 64'h1_0000, 64'd100 << 16, 0, 64'h1_0000};
        write_all(regs);
        pending_particles.push_back(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_particles.push_back(mk(FUNC_KICK, 32'h7fff_ffff, 32'h7fff_ffff,
                                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0));
        pending_particles.push_back(mk(FUNC_KICK_BIN, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'hffff_ffff, 10'h3ff));
        pending_particles.push_back(mk(FUNC_KICK_BIN, 0, 0, 0, 32'h8000_0000,
                                       32'h7fff_ffff, 32'hffff_ffff, 0));
        pending_particles.push_back(mk(FUNC_KICK_BIN, 0, 0, 0, 32'h1_0000, 32'hffff_0000,
                                       32'hffff_ffff, 0));
        pending_particles.push_back(mk(FUNC_KICK_BIN, 32'd3 << 16, 32'd4 << 16, 0, 5, -5,
                                       32'd7, 0));
        pending_particles.push_back(mk(FUNC_KICK_BIN, 32'd1023 << 16, 0, 0, 1, 1, 9, 0));
        pending_particles.push_back(mk(FUNC_KICK_BIN, 32'd1024 << 16, 0, 0, 1, 1, 9, 0));
        pending_particles.push_back(mk(FUNC_KICK, 32'd100 << 16, 0, 0, 1, 1, 0, 0));
        pending_particles.push_back(mk(FUNC_KICK, 32'd99 << 16, 0, 0, -1, -1, 0, 0));
        pending_particles.push_back(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_particles.push_back(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 5));
        pending_particles.push_back(mk(FUNC_READ_CLR, 0, 0, 0, 0, 0, 0, 0));
        pending_particles.push_back(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_particles.push_back(mk(FUNC_READ_CLR, 0, 0, 0, 0, 0, 0, 10'd1023));
        for (int i = 0; i < 250; i++)
            pending_particles.push_back(rand_particle());
        wait_idle();

        // phase 1: extreme offsets and gain, zero scale, largest radius and origin
        regs = '{64'h7fff_ffff, 64'h8000_0000, 64'h7fff_ffff, 64'h8000_0000_7fff_ffff,
                 64'h8000_0000, 64'h7fff_ffff, 64'h7fff_ffff, 0};
        write_all(regs);
        pending_particles.push_back(mk(FUNC_KICK_BIN, 32'h8000_0000, 32'h7fff_ffff,
                                       32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 3, 0));
        pending_particles.push_back(mk(FUNC_KICK, 32'h7fff_ffff, 32'h8000_0000, 0,
                                       32'h7fff_ffff, 0, 0, 0));
        for (int i = 0; i < 250; i++)
            pending_particles.push_back(rand_particle());
        wait_idle();

        // phase 2: no idling on either side, largest scale, maximum gain
        no_idle = 1'b1;
        regs = '{0, 0, 0, 0, 64'h7fff_ffff, 0, 0, 64'hffff_ffff};
        write_all(regs);
        for (int i = 0; i < 200; i++)
            pending_particles.push_back(rand_particle());
        wait_idle();
        no_idle = 1'b0;

        // random settings with small offsets and moderate bin widths
        for (int ph = 0; ph < 5; ph++)
        begin
            regs[0] = coord();
            regs[1] = coord();
            regs[2] = coord();
            regs[3] = {coord(), coord()};
            regs[4] = $urandom_range(0, 3) == 0 ? 64'($urandom) :
                      64'(32'($urandom_range(0, 1 << 18)) - 32'(1 << 17));
            regs[5] = $urandom_range(0, 2) == 0 ? 0 : 64'($urandom_range(0, 1 << 26));
            regs[6] = 64'($urandom_range(0, 1 << 22));
            regs[7] = 64'($urandom_range(0, 1 << 20));
            write_all(regs);
            for (int i = 0; i < 210; i++)
                pending_particles.push_back(rand_particle());
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (!had_error && expected_kicks.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### particle_coriolis_kick_radial_binning.f
src/pckrb_pkg.sv
src/particle_coriolis_kick_radial_binning.sv
dv/tb_particle_coriolis_kick_radial_binning.sv
